[rtl/core/sfp_pkg.sv]
// Types, constants and small functions shared by the starfield projection block.
// Depends on nothing; the top level and the testbench take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package sfp_pkg;

    localparam int IDX_W     = 10;
    localparam int RAND_W    = 16;
    localparam int POS_W     = 24;
    localparam int DEPTH_W   = 16;
    localparam int SPEED_W   = 2;
    localparam int SIZE_W    = 13;
    localparam int PIX_W     = 12;
    localparam int GRAY_W    = 8;
    localparam int PROD_W    = 28;
    localparam int DEN_W     = 24;
    localparam int QUO_W     = 16;
    localparam int NUM_W     = 37;
    localparam int ENTRY_W   = 2 * POS_W + DEPTH_W + SPEED_W;

    localparam int SPAWN_STEP = 240;
    localparam int SPAWN_BIAS = 7864320;

    localparam int ST_READ  = 0;
    localparam int ST_SEL   = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_NUM   = 3;
    localparam int NUM_STG  = ST_NUM + 1 + QUO_W;
    localparam int ST_LAST  = NUM_STG - 1;

    localparam logic OP_SPAWN   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic                 inr;
        logic [IDX_W-1:0]     idx;
        logic [RAND_W-1:0]    rx;
        logic [RAND_W-1:0]    ry;
        logic                 rs;
        logic                 resp;
        logic [POS_W-1:0]     xpos;
        logic [POS_W-1:0]     ypos;
        logic [DEPTH_W-1:0]   depth;
        logic [SPEED_W-1:0]   speed;
        logic [PROD_W-1:0]    prodx;
        logic [PROD_W-1:0]    prody;
        logic                 negx;
        logic                 negy;
        logic [DEN_W-1:0]     remx;
        logic [DEN_W-1:0]     remy;
        logic [QUO_W-1:0]     quox;
        logic [QUO_W-1:0]     quoy;
    } stg_t;

    function automatic logic [POS_W-1:0] spawn_pos(input logic [RAND_W-1:0] r);
        spawn_pos = POS_W'(int'(r) * SPAWN_STEP - SPAWN_BIAS);
    endfunction

endpackage
`default_nettype wire

[rtl/core/sfp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/starfield_projection.sv]
// Star table with perspective projection: one RAM of star state and a pipelined divider.
// Depends on sfp_pkg and sfp_ram.
//
// Items arrive on the s_ channel: s_tuser carries the operation (spawn or advance),
// s_tdata the star index and the random fields. Each item gives one transfer on the
// m_ channel with the pixel, its grey level and the visible and respawned flags.
// The user must write screen width and height on the cfg_ channel only while the block is
// idle; the block itself does not enforce this. One item is taken per cycle while the
// pipeline is not stopped; a result passes through the state RAM read, three set-up stages
// and the sixteen stages of the restoring divider into the output register. An item for a
// star that is still in flight waits until the earlier item has written the star back.
// When the receiver stalls, the pipeline keeps moving until its last stage holds a
// result that cannot be handed on; then it stops and s_tready falls.
// Reset empties the pipeline and sets the screen to 640 by 480; the star RAM keeps
// its contents, and a star must be spawned before it is advanced.
`timescale 1ns / 1ps
`default_nettype none
module starfield_projection #(
    parameter int NUM_STARS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // star_index, rand_x, rand_y, rand_speed, zero fill
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // pixel_x, pixel_y, gray_level
    output logic      [1:0]  m_tuser,   // visible, respawned
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

    sfp_pkg::stg_t stg_reg  [sfp_pkg::NUM_STG];
    sfp_pkg::stg_t stg_next [sfp_pkg::NUM_STG];

    logic [sfp_pkg::SIZE_W-1:0]  width_reg, height_reg;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;
    logic [1:0]                  out_user_reg;
    logic [31:0]                 out_data_next;
    logic [1:0]                  out_user_next;

    logic                        en, hazard, accept;
    logic [sfp_pkg::ENTRY_W-1:0] rd_data, wr_data;
    logic                        wr_en;
    logic [sfp_pkg::IDX_W-1:0]   in_idx;

    assign in_idx    = s_tdata[9:0];
    assign cfg_ready = 1'b1;
    assign en        = !stg_reg[sfp_pkg::ST_LAST].valid || !out_valid_reg || m_tready;

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < sfp_pkg::NUM_STG; k++)
        begin
            if (stg_reg[k].valid && stg_reg[k].inr && stg_reg[k].idx == in_idx)
            begin
                hazard = 1'b1;
            end
        end
    end

    assign s_tready = en && !hazard;
    assign accept   = s_tvalid && s_tready;

    sfp_ram #(
        .WIDTH(sfp_pkg::ENTRY_W),
        .DEPTH(NUM_STARS)
    ) u_star_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(AW'(stg_reg[sfp_pkg::ST_LAST].idx)),
        .wdata(wr_data),
        .re   (accept),
        .raddr(AW'(in_idx)),
        .rdata(rd_data)
    );

    always_comb
    begin
        logic signed [sfp_pkg::DEPTH_W:0] d;
        logic                             resp1;
        logic signed [sfp_pkg::NUM_W-1:0] numx, numy, magx, magy;
        logic [sfp_pkg::DEN_W-1:0]        den;
        logic [sfp_pkg::DEN_W:0]          tx, ty;
        logic [sfp_pkg::IDX_W:0]          idx1;

        stg_next[sfp_pkg::ST_READ]       = '0;
        stg_next[sfp_pkg::ST_READ].valid = accept;
        stg_next[sfp_pkg::ST_READ].op    = s_tuser;
        stg_next[sfp_pkg::ST_READ].inr   = int'(in_idx) < NUM_STARS;
        stg_next[sfp_pkg::ST_READ].idx   = in_idx;
        stg_next[sfp_pkg::ST_READ].rx    = s_tdata[25:10];
        stg_next[sfp_pkg::ST_READ].ry    = s_tdata[41:26];
        stg_next[sfp_pkg::ST_READ].rs    = s_tdata[42];

        stg_next[sfp_pkg::ST_SEL] = stg_reg[sfp_pkg::ST_READ];
        d = $signed({rd_data[63], rd_data[63:48]})
            - $signed({15'd0, rd_data[65:64]});
        resp1 = (stg_reg[sfp_pkg::ST_READ].op == sfp_pkg::OP_SPAWN) || d[16] || (d == '0);
        idx1  = {1'b0, stg_reg[sfp_pkg::ST_READ].idx} + 11'd1;
        if (resp1)
        begin
            stg_next[sfp_pkg::ST_SEL].xpos  = sfp_pkg::spawn_pos(stg_reg[sfp_pkg::ST_READ].rx);
            stg_next[sfp_pkg::ST_SEL].ypos  = sfp_pkg::spawn_pos(stg_reg[sfp_pkg::ST_READ].ry);
            stg_next[sfp_pkg::ST_SEL].depth = {5'd0, idx1};
            stg_next[sfp_pkg::ST_SEL].speed = {1'b1, stg_reg[sfp_pkg::ST_READ].rs};
        end
        else
        begin
            stg_next[sfp_pkg::ST_SEL].xpos  = rd_data[23:0];
            stg_next[sfp_pkg::ST_SEL].ypos  = rd_data[47:24];
            stg_next[sfp_pkg::ST_SEL].depth = d[15:0];
            stg_next[sfp_pkg::ST_SEL].speed = rd_data[65:64];
        end
        stg_next[sfp_pkg::ST_SEL].resp = resp1;

        stg_next[sfp_pkg::ST_MUL] = stg_reg[sfp_pkg::ST_SEL];
        stg_next[sfp_pkg::ST_MUL].prodx = stg_reg[sfp_pkg::ST_SEL].depth * width_reg[12:1];
        stg_next[sfp_pkg::ST_MUL].prody = stg_reg[sfp_pkg::ST_SEL].depth * height_reg[12:1];

        stg_next[sfp_pkg::ST_NUM] = stg_reg[sfp_pkg::ST_MUL];
        numx = $signed({{13{stg_reg[sfp_pkg::ST_MUL].xpos[23]}}, stg_reg[sfp_pkg::ST_MUL].xpos})
             + $signed({1'b0, stg_reg[sfp_pkg::ST_MUL].prodx, 8'd0});
        numy = $signed({{13{stg_reg[sfp_pkg::ST_MUL].ypos[23]}}, stg_reg[sfp_pkg::ST_MUL].ypos})
             + $signed({1'b0, stg_reg[sfp_pkg::ST_MUL].prody, 8'd0});
        magx = numx[36] ? -numx : numx;
        magy = numy[36] ? -numy : numy;
        stg_next[sfp_pkg::ST_NUM].negx = numx[36];
        stg_next[sfp_pkg::ST_NUM].negy = numy[36];
        stg_next[sfp_pkg::ST_NUM].remx = {4'd0, magx[35:16]};
        stg_next[sfp_pkg::ST_NUM].remy = {4'd0, magy[35:16]};
        stg_next[sfp_pkg::ST_NUM].quox = magx[15:0];
        stg_next[sfp_pkg::ST_NUM].quoy = magy[15:0];

        for (int k = sfp_pkg::ST_NUM + 1; k < sfp_pkg::NUM_STG; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            den = {stg_reg[k-1].depth, 8'd0};
            tx  = {stg_reg[k-1].remx, stg_reg[k-1].quox[15]};
            ty  = {stg_reg[k-1].remy, stg_reg[k-1].quoy[15]};
            if (tx >= {1'b0, den})
            begin
                stg_next[k].remx = 24'(tx - {1'b0, den});
                stg_next[k].quox = {stg_reg[k-1].quox[14:0], 1'b1};
            end
            else
            begin
                stg_next[k].remx = tx[23:0];
                stg_next[k].quox = {stg_reg[k-1].quox[14:0], 1'b0};
            end
            if (ty >= {1'b0, den})
            begin
                stg_next[k].remy = 24'(ty - {1'b0, den});
                stg_next[k].quoy = {stg_reg[k-1].quoy[14:0], 1'b1};
            end
            else
            begin
                stg_next[k].remy = ty[23:0];
                stg_next[k].quoy = {stg_reg[k-1].quoy[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sfp_pkg::stg_t              f;
        logic                       off;
        logic [sfp_pkg::IDX_W:0]    idx1;
        logic [sfp_pkg::GRAY_W-1:0] c;

        f    = stg_reg[sfp_pkg::ST_LAST];
        off  = (f.negx && f.quox != '0) || (f.quox >= {3'd0, width_reg})
            || (f.negy && f.quoy != '0) || (f.quoy >= {3'd0, height_reg});
        idx1 = {1'b0, f.idx} + 11'd1;
        c    = idx1[9:2];

        out_data_next = '0;
        out_user_next = '0;
        if (f.inr)
        begin
            if (f.op == sfp_pkg::OP_SPAWN || off)
            begin
                out_user_next = 2'b10;
            end
            else
            begin
                out_data_next = {(c == '0) ? 8'd0 : ~c, f.quoy[11:0], f.quox[11:0]};
                out_user_next = {f.resp, 1'b1};
            end
        end

        wr_en = en && f.valid && f.inr;
        if (f.op == sfp_pkg::OP_ADVANCE && off)
        begin
            wr_data = {2'b10 | {1'b0, f.rs}, 5'd0, idx1,
                       sfp_pkg::spawn_pos(f.ry), sfp_pkg::spawn_pos(f.rx)};
        end
        else
        begin
            wr_data = {f.speed, f.depth, f.ypos, f.xpos};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sfp_pkg::NUM_STG; k++)
            begin
                stg_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
            width_reg     <= 13'd640;
            height_reg    <= 13'd480;
        end
        else
        begin
            if (en)
            begin
                for (int k = 0; k < sfp_pkg::NUM_STG; k++)
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
            if (en && stg_reg[sfp_pkg::ST_LAST].valid)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
                out_user_reg  <= out_user_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    sfp_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    sfp_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:                    width_reg  <= width_reg;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

[verif/starfield_projection_test.sv]
// Self-checking testbench for starfield_projection: directed rows, then random spawn and
// advance items under random idling on both streams and at several screen sizes, checked
// against a built-in predictor. Depends on sfp_pkg and the starfield_projection RTL.
`timescale 1ns / 1ps
module starfield_projection_test;

    localparam int   PIX_W             = sfp_pkg::PIX_W;
    localparam int   GRAY_W            = sfp_pkg::GRAY_W;
    localparam int   RAND_W            = sfp_pkg::RAND_W;
    localparam int   IDX_W             = sfp_pkg::IDX_W;
    localparam int   SPAWN_STEP        = sfp_pkg::SPAWN_STEP;
    localparam int   SPAWN_BIAS        = sfp_pkg::SPAWN_BIAS;
    localparam logic OP_SPAWN          = sfp_pkg::OP_SPAWN;
    localparam logic OP_ADVANCE        = sfp_pkg::OP_ADVANCE;
    localparam logic REG_SCREEN_WIDTH  = sfp_pkg::REG_SCREEN_WIDTH;
    localparam logic REG_SCREEN_HEIGHT = sfp_pkg::REG_SCREEN_HEIGHT;

    localparam int NSTARS      = 1024;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int DIR_ROWS    = 18;

    typedef struct packed {
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  py;
        logic [GRAY_W-1:0] gray;
        logic              vis;
        logic              resp;
    } pixel_t;

    typedef struct {
        logic              op;
        int                idx;
        logic [RAND_W-1:0] rx;
        logic [RAND_W-1:0] ry;
        logic              rs;
        bit                typed;
        pixel_t            want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_SCREEN_WIDTH;
    logic [12:0] cfg_data = '0;

    int     star_x [NSTARS];
    int     star_y [NSTARS];
    int     star_d [NSTARS];
    int     star_v [NSTARS];
    bit     spawned [NSTARS];
    int     width_px = 640;
    int     height_px = 480;
    pixel_t pending_pixels [$];
    int     fails = 0;
    int     idle_cycles = 0;
    int     hold_request = 0;
    bit     steady_rx = 0;

    row_t dir_rows [DIR_ROWS] = '{
        '{OP_SPAWN,   0,    16'h0000, 16'h0000, 1'b0, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 0,    16'h8000, 16'h8000, 1'b0, 1, '{12'd320, 12'd240, 8'd0, 1'b1, 1'b1}},
        '{OP_ADVANCE, 0,    16'h0000, 16'h0000, 1'b0, 0, '0},
        '{OP_SPAWN,   1023, 16'hffff, 16'hffff, 1'b1, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 1023, 16'h0000, 16'h0000, 1'b0, 0, '0},
        '{OP_ADVANCE, 1023, 16'hffff, 16'h0000, 1'b1, 0, '0},
        '{OP_SPAWN,   3,    16'hffff, 16'h0000, 1'b1, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 3,    16'h8000, 16'h8000, 1'b0, 0, '0},
        '{OP_SPAWN,   512,  16'h5555, 16'haaaa, 1'b0, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 512,  16'haaaa, 16'h5555, 1'b1, 0, '0},
        '{OP_ADVANCE, 512,  16'haaaa, 16'h5555, 1'b1, 0, '0},
        '{OP_SPAWN,   1,    16'h8000, 16'h8000, 1'b1, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 1,    16'h7fff, 16'h8001, 1'b0, 0, '0},
        '{OP_ADVANCE, 1,    16'h7fff, 16'h8001, 1'b0, 0, '0},
        '{OP_SPAWN,   1019, 16'h7fff, 16'h8000, 1'b0, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 1019, 16'h1234, 16'hfedc, 1'b1, 0, '0},
        '{OP_SPAWN,   1020, 16'h8100, 16'h7f00, 1'b0, 1, '{12'd0, 12'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADVANCE, 1020, 16'h0f0f, 16'hf0f0, 1'b1, 0, '0}
    };

    starfield_projection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void place_star(int idx, logic [RAND_W-1:0] rx, logic [RAND_W-1:0] ry,
                                       logic rs);
        star_x[idx] = int'(rx) * SPAWN_STEP - SPAWN_BIAS;
        star_y[idx] = int'(ry) * SPAWN_STEP - SPAWN_BIAS;
        star_d[idx] = idx + 1;
        star_v[idx] = 2 + int'(rs);
    endfunction

    function automatic longint screen_coord(int pos, int depth, int size);
        longint den;
        den = longint'(depth) * 256;
        return (longint'(pos) + den * longint'(size >> 1)) / den;
    endfunction

    function automatic pixel_t move_star(logic op, int idx, logic [RAND_W-1:0] rx,
                                         logic [RAND_W-1:0] ry, logic rs);
        pixel_t res;
        longint cx;
        longint cy;
        int     shade;
        res = '0;
        if (op == OP_SPAWN) begin
            place_star(idx, rx, ry, rs);
            res.resp = 1'b1;
            return res;
        end
        star_d[idx] = star_d[idx] - star_v[idx];
        if (star_d[idx] <= 0) begin
            place_star(idx, rx, ry, rs);
            res.resp = 1'b1;
        end
        cx = screen_coord(star_x[idx], star_d[idx], width_px);
        cy = screen_coord(star_y[idx], star_d[idx], height_px);
        if (cx < 0 || cx > width_px - 1 || cy < 0 || cy > height_px - 1) begin
            place_star(idx, rx, ry, rs);
            res.resp = 1'b1;
            return res;
        end
        shade = ((idx + 1) >> 2) & 255;
        res.px = cx[PIX_W-1:0];
        res.py = cy[PIX_W-1:0];
        res.gray = (shade == 0) ? 8'd0 : GRAY_W'(255 - shade);
        res.vis = 1'b1;
        return res;
    endfunction

    task automatic send_star(logic op, int idx, logic [RAND_W-1:0] rx, logic [RAND_W-1:0] ry,
                             logic rs, bit typed, pixel_t want);
        pixel_t guess;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, rs, ry, rx, IDX_W'(idx)};
        do @(posedge clk); while (!s_tready);
        guess = move_star(op, idx, rx, ry, rs);
        if (op == OP_SPAWN)
            spawned[idx] = 1;
        pending_pixels.push_back(typed ? want : guess);
    endtask

    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70)
            return;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_screen(logic which, int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= 13'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (which == REG_SCREEN_WIDTH)
            width_px = value & 13'h1fff;
        else
            height_px = value & 13'h1fff;
    endtask

    task automatic random_items(int count);
        int   idx;
        logic op;
        for (int k = 0; k < count; k++) begin
            idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
            op = ($urandom_range(0, 99) < 30) ? OP_SPAWN : OP_ADVANCE;
            if (!spawned[idx])
                op = OP_SPAWN;
            send_star(op, idx, RAND_W'($urandom), RAND_W'($urandom), 1'($urandom), 0, '0);
            sender_gap();
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                m_tready <= 1'b0;
                hold_request--;
            end
            else if (steady_rx || $urandom_range(0, 99) < 75)
                m_tready <= 1'b1;
            else
                m_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (m_tvalid && m_tready)
        begin
            got = '{m_tdata[11:0], m_tdata[23:12], m_tdata[31:24], m_tuser[0], m_tuser[1]};
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected transfer on the result stream");
                fails++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.px !== want.px)
                begin
                    $error("pixel_x expected %0d actual %0d", want.px, got.px);
                    fails++;
                end
                if (got.py !== want.py)
                begin
                    $error("pixel_y expected %0d actual %0d", want.py, got.py);
                    fails++;
                end
                if (got.gray !== want.gray)
                begin
                    $error("gray_level expected %0d actual %0d", want.gray, got.gray);
                    fails++;
                end
                if (got.vis !== want.vis)
                begin
                    $error("visible expected %0d actual %0d", want.vis, got.vis);
                    fails++;
                end
                if (got.resp !== want.resp)
                begin
                    $error("respawned expected %0d actual %0d", want.resp, got.resp);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[starfield_projection] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steady_rx = 1;
        foreach (dir_rows[i])
            send_star(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].rx, dir_rows[i].ry,
                      dir_rows[i].rs, dir_rows[i].typed, dir_rows[i].want);
        steady_rx = 0;

        random_items(250);
        hold_request = 300;
        random_items(250);
        drain();

        write_screen(REG_SCREEN_WIDTH, 4096);
        write_screen(REG_SCREEN_HEIGHT, 4096);
        random_items(200);
        write_screen(REG_SCREEN_WIDTH, 1);
        write_screen(REG_SCREEN_HEIGHT, 1);
        random_items(150);
        write_screen(REG_SCREEN_WIDTH, 4096);
        random_items(150);
        write_screen(REG_SCREEN_WIDTH, $urandom_range(1, 4096));
        write_screen(REG_SCREEN_HEIGHT, $urandom_range(1, 4096));
        steady_rx = 1;
        random_items(100);
        steady_rx = 0;
        random_items(150);
        drain();

        if (fails == 0)
            $display("[starfield_projection] OK");
        else
            $display("[starfield_projection] ERROR");
        $finish;
    end

endmodule
